[sv/button_volume_power_controller_assert.svh]
// Assertion macros shared by the controller modules.
// Used through `include; needs no package.
`ifndef BUTTON_VOLUME_POWER_CONTROLLER_ASSERT_SVH
`define BUTTON_VOLUME_POWER_CONTROLLER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define BVP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("controller assertion failed");

// Next-cycle implication, disabled while reset is low
`define BVP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("controller assertion failed");

`endif

[sv/bvp_pkg.sv]
// Package for the button volume and power controller: request and result
// structs, configuration struct, register indexes, codes and reset values.
`timescale 1ns / 1ps

package bvp_pkg;

    // Register indexes on the configuration port
    typedef enum logic [3:0] {
        CFG_VOLUME_STEP      = 4'd0,
        CFG_VOLUME_MAX       = 4'd1,
        CFG_REMUTE_DELAY     = 4'd2,
        CFG_IDLE_LIMIT       = 4'd3,
        CFG_BATTERY_INTERVAL = 4'd4,
        CFG_LOW_THRESHOLD    = 4'd5,
        CFG_FULL_THRESHOLD   = 4'd6,
        CFG_OVER_THRESHOLD   = 4'd7
    } t_cfg_index;

    // Beep codes
    localparam logic [1:0] BEEP_NONE  = 2'd0;
    localparam logic [1:0] BEEP_STEP  = 2'd1;
    localparam logic [1:0] BEEP_LIMIT = 2'd2;

    // Mute action codes
    localparam logic [1:0] MUTE_NONE   = 2'd0;
    localparam logic [1:0] MUTE_UNMUTE = 2'd1;
    localparam logic [1:0] MUTE_MUTE   = 2'd2;

    // Battery classes
    localparam logic [1:0] BATT_NORMAL = 2'd0;
    localparam logic [1:0] BATT_LOW    = 2'd1;
    localparam logic [1:0] BATT_OVER   = 2'd2;
    localparam logic [1:0] BATT_FULL   = 2'd3;

    // Volume limits and reset level
    localparam logic [6:0] VOLUME_CEIL  = 7'd127;
    localparam logic [6:0] VOLUME_RESET = 7'd50;

    // Configuration reset values
    localparam logic [6:0]  RST_VOLUME_STEP      = 7'd10;
    localparam logic [6:0]  RST_VOLUME_MAX       = 7'd100;
    localparam logic [31:0] RST_REMUTE_DELAY     = 32'd800;
    localparam logic [31:0] RST_IDLE_LIMIT       = 32'd600000000;
    localparam logic [31:0] RST_BATTERY_INTERVAL = 32'd1000000;
    localparam logic [12:0] RST_LOW_THRESHOLD    = 13'd2700;
    localparam logic [12:0] RST_FULL_THRESHOLD   = 13'd3600;
    localparam logic [12:0] RST_OVER_THRESHOLD   = 13'd3870;

    typedef struct packed {
        logic [6:0]  volume_step;
        logic [6:0]  volume_max;
        logic [31:0] remute_delay;
        logic [31:0] idle_limit;
        logic [31:0] battery_interval;
        logic [12:0] low_threshold_mv;
        logic [12:0] full_threshold_mv;
        logic [12:0] over_threshold_mv;
    } t_cfg;

    typedef struct packed {
        logic [47:0] now_us;
        logic        big_ear;
        logic        small_ear;
        logic        playing;
        logic [12:0] pack_mv;
    } t_item;

    typedef struct packed {
        logic [6:0] volume_level;
        logic       volume_changed;
        logic [1:0] up_beep;
        logic [1:0] down_beep;
        logic [1:0] mute_action;
        logic       battery_valid;
        logic [1:0] battery_class;
        logic       low_battery_alarm;
        logic       power_off;
    } t_result;

endpackage

[sv/button_volume_power_controller.sv]
// Button volume and power controller. A request passes through the input
// register, then the result register.
// Throughput: one request per cycle; a stalled result blocks intake only once
// the request register behind it is also full.
// Reset (i_rst_n low, synchronous) empties both stages, resets the tick
// state and loads the configuration registers with their default values.
`timescale 1ns / 1ps
`include "button_volume_power_controller_assert.svh"

module button_volume_power_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_wr_en,
    input  logic [3:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [47:0] i_now_us,
    input  logic        i_big_ear,
    input  logic        i_small_ear,
    input  logic        i_playing,
    input  logic [12:0] i_pack_mv,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [6:0]  o_volume_level,
    output logic        o_volume_changed,
    output logic [1:0]  o_up_beep,
    output logic [1:0]  o_down_beep,
    output logic [1:0]  o_mute_action,
    output logic        o_battery_valid,
    output logic [1:0]  o_battery_class,
    output logic        o_low_battery_alarm,
    output logic        o_power_off
);

    bvp_pkg::t_cfg    cfg;
    bvp_pkg::t_item   r_in;
    bvp_pkg::t_result r_out;
    bvp_pkg::t_result tick_result;
    logic             r_in_valid,  n_in_valid;
    logic             r_out_valid, n_out_valid;
    logic             in_accept;
    logic             advance;

    bvp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_wr_en),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    bvp_tick u_tick (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in),
        .i_cfg     (cfg),
        .o_result  (tick_result)
    );

    // Move a request on when the result register is free or being drained
    assign advance    = r_in_valid && !(r_out_valid && i_out_stall);
    assign o_in_stall = r_in_valid && r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid  = in_accept || (r_in_valid && !advance);
        n_out_valid = advance || (r_out_valid && i_out_stall);
    end

    // Hold the stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Load request and result payloads
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in.now_us    <= i_now_us;
            r_in.big_ear   <= i_big_ear;
            r_in.small_ear <= i_small_ear;
            r_in.playing   <= i_playing;
            r_in.pack_mv   <= i_pack_mv;
        end
        if (advance) begin
            r_out <= tick_result;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_volume_level      = r_out.volume_level;
    assign o_volume_changed    = r_out.volume_changed;
    assign o_up_beep           = r_out.up_beep;
    assign o_down_beep         = r_out.down_beep;
    assign o_mute_action       = r_out.mute_action;
    assign o_battery_valid     = r_out.battery_valid;
    assign o_battery_class     = r_out.battery_class;
    assign o_low_battery_alarm = r_out.low_battery_alarm;
    assign o_power_off         = r_out.power_off;

    `BVP_ASSERT_NXT(a_advance_lands, i_clk, i_rst_n, advance, r_out_valid)
    `BVP_ASSERT_NXT(a_accept_held, i_clk, i_rst_n, in_accept, r_in_valid)
    `BVP_ASSERT_IMP(a_stall_full, i_clk, i_rst_n, o_in_stall, r_in_valid && !advance)

endmodule

[sv/bvp_cfg.sv]
// Configuration register file of the controller.
// Depends on bvp_pkg for the register struct, indexes and reset values.
`timescale 1ns / 1ps

module bvp_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  logic [3:0]        i_index,
    input  logic [31:0]       i_data,
    output bvp_pkg::t_cfg     o_cfg
);

    bvp_pkg::t_cfg r_cfg;
    bvp_pkg::t_cfg n_cfg;

    // Decode the write; unknown indexes leave everything alone
    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            case (bvp_pkg::t_cfg_index'(i_index))
                bvp_pkg::CFG_VOLUME_STEP:      n_cfg.volume_step       = i_data[6:0];
                bvp_pkg::CFG_VOLUME_MAX:       n_cfg.volume_max        = i_data[6:0];
                bvp_pkg::CFG_REMUTE_DELAY:     n_cfg.remute_delay      = i_data;
                bvp_pkg::CFG_IDLE_LIMIT:       n_cfg.idle_limit        = i_data;
                bvp_pkg::CFG_BATTERY_INTERVAL: n_cfg.battery_interval  = i_data;
                bvp_pkg::CFG_LOW_THRESHOLD:    n_cfg.low_threshold_mv  = i_data[12:0];
                bvp_pkg::CFG_FULL_THRESHOLD:   n_cfg.full_threshold_mv = i_data[12:0];
                bvp_pkg::CFG_OVER_THRESHOLD:   n_cfg.over_threshold_mv = i_data[12:0];
                default: n_cfg = r_cfg;
            endcase
        end
    end

    // Hold the registers, load defaults on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.volume_step       <= bvp_pkg::RST_VOLUME_STEP;
            r_cfg.volume_max        <= bvp_pkg::RST_VOLUME_MAX;
            r_cfg.remute_delay      <= bvp_pkg::RST_REMUTE_DELAY;
            r_cfg.idle_limit        <= bvp_pkg::RST_IDLE_LIMIT;
            r_cfg.battery_interval  <= bvp_pkg::RST_BATTERY_INTERVAL;
            r_cfg.low_threshold_mv  <= bvp_pkg::RST_LOW_THRESHOLD;
            r_cfg.full_threshold_mv <= bvp_pkg::RST_FULL_THRESHOLD;
            r_cfg.over_threshold_mv <= bvp_pkg::RST_OVER_THRESHOLD;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[sv/bvp_tick.sv]
// Per-tick logic: button edges, volume, remute deadline, battery class and
// poweroff latch, with their state. Depends on bvp_pkg and the assert header.
`timescale 1ns / 1ps
`include "button_volume_power_controller_assert.svh"

module bvp_tick (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  bvp_pkg::t_item    i_item,
    input  bvp_pkg::t_cfg     i_cfg,
    output bvp_pkg::t_result  o_result
);

    logic        r_big_prev,  n_big_prev;
    logic        r_small_prev, n_small_prev;
    logic [6:0]  r_volume,    n_volume;
    logic [47:0] r_deadline,  n_deadline;
    logic [47:0] r_last_act,  n_last_act;
    logic [47:0] r_last_batt, n_last_batt;
    logic        r_off_latched, n_off_latched;

    logic [48:0] batt_diff;
    logic [48:0] act_diff;
    logic [48:0] dl_sum;
    logic [47:0] dl_new;
    logic [7:0]  up_sum;
    logic [6:0]  vol_mid;
    logic        big_rise;
    logic        small_rise;
    logic        batt_hit;
    logic        activity;

    // Elapsed times and the new deadline, all in parallel on the old state
    assign batt_diff = {1'b0, i_item.now_us} - {1'b0, r_last_batt};
    assign act_diff  = {1'b0, i_item.now_us} - {1'b0, r_last_act};
    assign dl_sum    = {1'b0, i_item.now_us} + {17'd0, i_cfg.remute_delay};
    assign dl_new    = dl_sum[48] ? {48{1'b1}} : dl_sum[47:0];
    assign up_sum    = {1'b0, r_volume} + {1'b0, i_cfg.volume_step};

    assign big_rise   = i_item.big_ear & ~r_big_prev;
    assign small_rise = i_item.small_ear & ~r_small_prev;
    assign activity   = i_item.big_ear | i_item.small_ear | i_item.playing;
    assign batt_hit   = ~batt_diff[48] &&
                        (batt_diff[47:0] > {16'd0, i_cfg.battery_interval});

    // Next state and result of the tick
    always_comb begin
        n_big_prev    = i_item.big_ear;
        n_small_prev  = i_item.small_ear;
        n_volume      = r_volume;
        n_deadline    = r_deadline;
        n_last_act    = r_last_act;
        n_last_batt   = r_last_batt;
        n_off_latched = r_off_latched;
        vol_mid       = r_volume;

        o_result = '0;

        if (r_off_latched) begin
            // Latched off: freeze state, report volume and poweroff only
            n_big_prev   = r_big_prev;
            n_small_prev = r_small_prev;
            o_result.volume_level = r_volume;
            o_result.power_off    = 1'b1;
        end else begin
            // Battery class, low first, then over, then full
            if (batt_hit) begin
                o_result.battery_valid = 1'b1;
                n_last_batt = i_item.now_us;
                if (i_item.pack_mv < i_cfg.low_threshold_mv) begin
                    o_result.battery_class     = bvp_pkg::BATT_LOW;
                    o_result.low_battery_alarm = 1'b1;
                end else if (i_item.pack_mv > i_cfg.over_threshold_mv) begin
                    o_result.battery_class     = bvp_pkg::BATT_OVER;
                    o_result.low_battery_alarm = 1'b1;
                end else if (i_item.pack_mv > i_cfg.full_threshold_mv) begin
                    o_result.battery_class = bvp_pkg::BATT_FULL;
                end else begin
                    o_result.battery_class = bvp_pkg::BATT_NORMAL;
                end
            end

            // Up press, saturating at the top of the field
            if (big_rise) begin
                o_result.mute_action = bvp_pkg::MUTE_UNMUTE;
                n_deadline = dl_new;
                if (r_volume < i_cfg.volume_max) begin
                    vol_mid = up_sum[7] ? bvp_pkg::VOLUME_CEIL : up_sum[6:0];
                    o_result.volume_changed = 1'b1;
                    o_result.up_beep = bvp_pkg::BEEP_STEP;
                end else begin
                    o_result.up_beep = bvp_pkg::BEEP_LIMIT;
                end
            end
            n_volume = vol_mid;

            // Down press on the volume left by the up press
            if (small_rise) begin
                o_result.mute_action = bvp_pkg::MUTE_UNMUTE;
                n_deadline = dl_new;
                if (vol_mid >= i_cfg.volume_step) begin
                    n_volume = vol_mid - i_cfg.volume_step;
                    o_result.volume_changed = 1'b1;
                    o_result.down_beep = bvp_pkg::BEEP_STEP;
                end else begin
                    o_result.down_beep = bvp_pkg::BEEP_LIMIT;
                end
            end

            // Remute; a fresh deadline is never behind now, so only an old one fires
            if (!big_rise && !small_rise && (r_deadline != 48'd0) &&
                (i_item.now_us > r_deadline)) begin
                n_deadline = 48'd0;
                o_result.mute_action = i_item.playing ? bvp_pkg::MUTE_UNMUTE
                                                      : bvp_pkg::MUTE_MUTE;
            end

            // Activity resets the idle clock; otherwise test the timeout
            if (activity) begin
                n_last_act = i_item.now_us;
            end else if (~act_diff[48] &&
                         (act_diff[47:0] > {16'd0, i_cfg.idle_limit})) begin
                n_off_latched = 1'b1;
            end

            o_result.volume_level = n_volume;
            o_result.power_off    = n_off_latched;
        end
    end

    // Advance state only when the request moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_big_prev    <= 1'b0;
            r_small_prev  <= 1'b0;
            r_volume      <= bvp_pkg::VOLUME_RESET;
            r_deadline    <= 48'd0;
            r_last_act    <= 48'd0;
            r_last_batt   <= 48'd0;
            r_off_latched <= 1'b0;
        end else if (i_advance) begin
            r_big_prev    <= n_big_prev;
            r_small_prev  <= n_small_prev;
            r_volume      <= n_volume;
            r_deadline    <= n_deadline;
            r_last_act    <= n_last_act;
            r_last_batt   <= n_last_batt;
            r_off_latched <= n_off_latched;
        end
    end

    `BVP_ASSERT_NXT(a_off_sticky, i_clk, i_rst_n, r_off_latched, r_off_latched)
    `BVP_ASSERT_IMP(a_off_quiet, i_clk, i_rst_n, r_off_latched,
        !o_result.volume_changed && (o_result.mute_action == bvp_pkg::MUTE_NONE) &&
        !o_result.battery_valid)
    `BVP_ASSERT_IMP(a_batt_idle, i_clk, i_rst_n, !o_result.battery_valid,
        (o_result.battery_class == bvp_pkg::BATT_NORMAL) && !o_result.low_battery_alarm)
    `BVP_ASSERT_IMP(a_change_beep, i_clk, i_rst_n, o_result.volume_changed,
        (o_result.up_beep == bvp_pkg::BEEP_STEP) || (o_result.down_beep == bvp_pkg::BEEP_STEP))

endmodule
